// ===== rtl/core/fswb_pkg.sv =====
`default_nettype none

package fswb_pkg;

  // Default geometry of the flash and of a request.
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int ADDR_BITS_DEF    = 21;
  localparam int LEN_BITS_DEF     = 16;

  // Operation codes carried on the result channel.
  localparam logic [2:0] OP_LOAD        = 3'd0;
  localparam logic [2:0] OP_PROG_BUF    = 3'd1;
  localparam logic [2:0] OP_PROG_DIRECT = 3'd2;
  localparam logic [2:0] OP_COPY        = 3'd3;
  localparam logic [2:0] OP_DONE        = 3'd4;

  // Request type codes.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // One operation as it leaves the block.
  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  sector_index;
    logic [11:0] buffer_offset;
    logic [12:0] byte_count;
    logic [15:0] source_offset;
    logic [15:0] done_length;
    logic        last;
  } fswb_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/fswb_len_unit.sv =====
`default_nettype none

// Shared length unit: compares the remaining length with a chunk size and
// gives the bytes taken by this step and the length left after it.
module fswb_len_unit #(
  parameter int LEN_BITS = 16,
  parameter int SB_BITS  = 12,
  localparam int W = (LEN_BITS > SB_BITS + 1) ? LEN_BITS : SB_BITS + 1
) (
  input  wire logic [LEN_BITS-1:0] len,
  input  wire logic [SB_BITS:0]    amt,
  output logic      [LEN_BITS-1:0] len_left,
  output logic      [W-1:0]        take,
  output logic                     fits
);

  logic [W:0] diff;

  // One subtraction; its borrow tells whether the chunk fits.
  assign diff     = (W + 1)'(len) - (W + 1)'(amt);
  assign fits     = !diff[W];
  assign take     = fits ? W'(amt) : W'(len);
  assign len_left = fits ? diff[LEN_BITS-1:0] : '0;

endmodule

`default_nettype wire

// ===== rtl/core/flash_sector_writeback_buffer.sv =====
`default_nettype none

// A request is taken only in the idle state, so a new request is not accepted
// until the done item of the last one has been registered. Each sequencer step
// emits at most one operation, which the output register holds while the output
// is stalled. At most four sequencer steps of a request emit nothing.
// Reset (synchronous): buffer empty, held sector 0, no result pending.
module flash_sector_writeback_buffer
  import fswb_pkg::*;
#(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int LEN_BITS     = LEN_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 req_type,
  input  wire logic [ADDR_BITS-1:0] start_addr,
  input  wire logic [LEN_BITS-1:0]  length,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic      [2:0]           op,
  output logic      [8:0]           sector_index,
  output logic      [11:0]          buffer_offset,
  output logic      [12:0]          byte_count,
  output logic      [15:0]          source_offset,
  output logic      [15:0]          done_length,
  output logic                      last
);

  // Sector size is a power of two; sector numbers wrap at the flash size
  // and are kept to nine bits.
  localparam int SB_BITS  = $clog2(SECTOR_BYTES);
  localparam int W        = (LEN_BITS > SB_BITS + 1) ? LEN_BITS : SB_BITS + 1;
  localparam int SEC_RAW  = ADDR_BITS - SB_BITS;
  localparam int SEC_KEEP = (SEC_RAW > 9) ? 9 : SEC_RAW;
  localparam logic [8:0]       SEC_MASK = 9'((1 << SEC_KEEP) - 1);
  localparam logic [SB_BITS:0] SB_FULL  = (SB_BITS + 1)'(SECTOR_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_HEAD,
    S_HEAD_PROG,
    S_BODY,
    S_TAIL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_CLEAN = 2'd1,
    ST_DIRTY = 2'd2
  } status_t;

  state_t               state, state_next;
  status_t              status, status_next;
  logic [8:0]           held, held_next;
  logic [8:0]           sec, sec_next;
  logic                 is_flush;
  logic [LEN_BITS-1:0]  len, len_next;
  logic [LEN_BITS-1:0]  src, src_next;
  logic [LEN_BITS-1:0]  total;
  logic [SB_BITS-1:0]   offset;
  logic [ADDR_BITS-1:0] addr_sec;
  logic [SB_BITS:0]     room;
  logic [SB_BITS:0]     amt;
  logic [LEN_BITS-1:0]  len_left;
  logic [W-1:0]         take;
  logic                 fits;
  logic                 adv;
  logic                 emit;
  fswb_res_t            item;
  fswb_res_t            res;
  logic [31:0]          take32, len32, off32, src32, total32;

  assign req_stall = (state != S_IDLE);
  assign adv       = !res_valid || !res_stall;

  assign addr_sec = start_addr >> SB_BITS;
  assign room     = SB_FULL - {1'b0, offset};
  assign amt      = (state == S_HEAD) ? room : SB_FULL;

  fswb_len_unit #(
    .LEN_BITS (LEN_BITS),
    .SB_BITS  (SB_BITS)
  ) u_len (
    .len      (len),
    .amt      (amt),
    .len_left (len_left),
    .take     (take),
    .fits     (fits)
  );

  // Widened copies so that each output field takes its own low bits.
  assign take32  = 32'(take);
  assign len32   = 32'(len);
  assign off32   = 32'(offset);
  assign src32   = 32'(src);
  assign total32 = 32'(total);

  // Sequencer decisions: at most one operation per step.
  always_comb begin
    state_next  = state;
    status_next = status;
    held_next   = held;
    sec_next    = sec;
    len_next    = len;
    src_next    = src;
    emit        = 1'b0;
    item        = '0;
    unique case (state)
      S_IDLE: begin
      end
      S_START: begin
        if (is_flush) begin
          if (status == ST_DIRTY) begin
            emit              = 1'b1;
            item.op           = OP_PROG_BUF;
            item.sector_index = held;
            status_next       = ST_CLEAN;
          end
          state_next = S_DONE;
        end else if (len == '0) begin
          state_next = S_DONE;
        end else begin
          // First use of an empty buffer loads the start sector.
          if (status == ST_EMPTY) begin
            emit              = 1'b1;
            item.op           = OP_LOAD;
            item.sector_index = sec;
            held_next         = sec;
            status_next       = ST_CLEAN;
          end
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (offset == '0) begin
          state_next = S_BODY;
        end else if (held != sec) begin
          // Switch sectors: write back a dirty buffer, then load.
          emit = 1'b1;
          if (status == ST_DIRTY) begin
            item.op           = OP_PROG_BUF;
            item.sector_index = held;
          end else begin
            item.op           = OP_LOAD;
            item.sector_index = sec;
            held_next         = sec;
          end
          status_next = ST_CLEAN;
        end else begin
          emit               = 1'b1;
          item.op            = OP_COPY;
          item.sector_index  = sec;
          item.buffer_offset = off32[11:0];
          item.byte_count    = take32[12:0];
          len_next           = len_left;
          src_next           = src + LEN_BITS'(take);
          sec_next           = (sec + 9'd1) & SEC_MASK;
          if (fits) begin
            state_next = S_HEAD_PROG;
          end else begin
            status_next = ST_DIRTY;
            state_next  = S_BODY;
          end
        end
      end
      S_HEAD_PROG: begin
        // The head reached the end of its sector: program it back.
        emit              = 1'b1;
        item.op           = OP_PROG_BUF;
        item.sector_index = held;
        status_next       = ST_CLEAN;
        state_next        = S_BODY;
      end
      S_BODY: begin
        if (fits) begin
          emit               = 1'b1;
          item.op            = OP_PROG_DIRECT;
          item.sector_index  = sec;
          item.byte_count    = take32[12:0];
          item.source_offset = src32[15:0];
          if (status != ST_EMPTY && held == sec) begin
            status_next = ST_EMPTY;
          end
          len_next = len_left;
          src_next = src + LEN_BITS'(take);
          sec_next = (sec + 9'd1) & SEC_MASK;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        if (len == '0) begin
          state_next = S_DONE;
        end else if (status == ST_EMPTY || held != sec) begin
          emit = 1'b1;
          if (status == ST_DIRTY) begin
            item.op           = OP_PROG_BUF;
            item.sector_index = held;
          end else begin
            item.op           = OP_LOAD;
            item.sector_index = sec;
            held_next         = sec;
          end
          status_next = ST_CLEAN;
        end else begin
          emit               = 1'b1;
          item.op            = OP_COPY;
          item.sector_index  = sec;
          item.byte_count    = len32[12:0];
          item.source_offset = src32[15:0];
          status_next        = ST_DIRTY;
          state_next         = S_DONE;
        end
      end
      S_DONE: begin
        emit       = 1'b1;
        item.op    = OP_DONE;
        item.last  = 1'b1;
        if (!is_flush) begin
          item.done_length = total32[15:0];
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, buffer tracking and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= ST_EMPTY;
      held      <= '0;
      res_valid <= 1'b0;
    end else if (state == S_IDLE) begin
      if (adv) begin
        res_valid <= 1'b0;
      end
      if (req_valid) begin
        is_flush <= (req_type == REQ_FLUSH);
        len      <= length;
        total    <= length;
        src      <= '0;
        offset   <= start_addr[SB_BITS-1:0];
        sec      <= 9'(addr_sec) & SEC_MASK;
        state    <= S_START;
      end
    end else if (adv) begin
      state     <= state_next;
      status    <= status_next;
      held      <= held_next;
      sec       <= sec_next;
      len       <= len_next;
      src       <= src_next;
      res_valid <= emit;
      if (emit) begin
        res <= item;
      end
    end
  end

  assign op            = res.op;
  assign sector_index  = res.sector_index;
  assign buffer_offset = res.buffer_offset;
  assign byte_count    = res.byte_count;
  assign source_offset = res.source_offset;
  assign done_length   = res.done_length;
  assign last          = res.last;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb
  import fswb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Buffer status as tracked by the predictor.
  typedef enum logic [1:0] {
    BUF_EMPTY = 2'd0,
    BUF_CLEAN = 2'd1,
    BUF_DIRTY = 2'd2
  } buf_state_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     req_valid;
  logic                     req_stall;
  logic                     req_type;
  logic [ADDR_BITS_DEF-1:0] start_addr;
  logic [LEN_BITS_DEF-1:0]  length;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic [2:0]               op;
  logic [8:0]               sector_index;
  logic [11:0]              buffer_offset;
  logic [12:0]              byte_count;
  logic [15:0]              source_offset;
  logic [15:0]              done_length;
  logic                     last;

  // Predicted operations not yet seen on the result channel.
  fswb_res_t   pending_ops[$];
  // Predictor copy of the buffer state.
  logic [8:0]  held_sec;
  buf_state_t  buf_state;

  int unsigned bad_results  = 0;
  int unsigned rx_hold_left = 0;
  bit          tx_idle_on   = 1'b1;
  bit          rx_idle_on   = 1'b1;

  flash_sector_writeback_buffer dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .start_addr    (start_addr),
    .length        (length),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .op            (op),
    .sector_index  (sector_index),
    .buffer_offset (buffer_offset),
    .byte_count    (byte_count),
    .source_offset (source_offset),
    .done_length   (done_length),
    .last          (last)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append one predicted operation; only the done item closes a request.
  function automatic void push_op(input logic [2:0] code, input logic [8:0] sec,
                                  input logic [11:0] boff, input logic [12:0] cnt,
                                  input logic [15:0] src, input logic [15:0] dlen);
    fswb_res_t item;
    item.op            = code;
    item.sector_index  = sec;
    item.buffer_offset = boff;
    item.byte_count    = cnt;
    item.source_offset = src;
    item.done_length   = dlen;
    item.last          = (code == OP_DONE);
    pending_ops.push_back(item);
  endfunction

  // Bring a sector into the buffer, writing back a dirty one first.
  function automatic void switch_sector(input logic [8:0] sec);
    if (buf_state == BUF_DIRTY) begin
      push_op(OP_PROG_BUF, held_sec, '0, '0, '0, '0);
    end
    push_op(OP_LOAD, sec, '0, '0, '0, '0);
    held_sec  = sec;
    buf_state = BUF_CLEAN;
  endfunction

  // Work out the operation list of one request and update the buffer state.
  function automatic void predict_ops(input logic rtype, input logic [ADDR_BITS_DEF-1:0] addr,
                                      input logic [LEN_BITS_DEF-1:0] len_in);
    logic [8:0]  sec;
    logic [11:0] offs;
    int unsigned remaining;
    int unsigned src;
    int unsigned room;
    int unsigned cnt;
    sec       = 9'(addr / SECTOR_BYTES_DEF);
    offs      = 12'(addr % SECTOR_BYTES_DEF);
    remaining = len_in;
    src       = 0;

    // A flush writes back only a dirty buffer.
    if (rtype == REQ_FLUSH) begin
      if (buf_state == BUF_DIRTY) begin
        push_op(OP_PROG_BUF, held_sec, '0, '0, '0, '0);
        buf_state = BUF_CLEAN;
      end
      push_op(OP_DONE, '0, '0, '0, '0, '0);
      return;
    end

    if (remaining == 0) begin
      push_op(OP_DONE, '0, '0, '0, '0, '0);
      return;
    end

    // First use loads the start sector.
    if (buf_state == BUF_EMPTY) begin
      push_op(OP_LOAD, sec, '0, '0, '0, '0);
      held_sec  = sec;
      buf_state = BUF_CLEAN;
    end

    // Unaligned head goes through the buffer.
    if (offs != 0) begin
      room = SECTOR_BYTES_DEF - offs;
      cnt  = (remaining < room) ? remaining : room;
      if (held_sec != sec) begin
        switch_sector(sec);
      end
      push_op(OP_COPY, sec, offs, 13'(cnt), '0, '0);
      if (cnt == room) begin
        push_op(OP_PROG_BUF, sec, '0, '0, '0, '0);
        buf_state = BUF_CLEAN;
      end else begin
        buf_state = BUF_DIRTY;
      end
      remaining = remaining - cnt;
      src       = src + cnt;
      sec       = sec + 9'd1;
    end

    // Whole sectors are programmed directly; covering the held one empties it.
    while (remaining >= SECTOR_BYTES_DEF) begin
      push_op(OP_PROG_DIRECT, sec, '0, 13'(SECTOR_BYTES_DEF), 16'(src), '0);
      if (buf_state != BUF_EMPTY && held_sec == sec) begin
        buf_state = BUF_EMPTY;
      end
      remaining = remaining - SECTOR_BYTES_DEF;
      src       = src + SECTOR_BYTES_DEF;
      sec       = sec + 9'd1;
    end

    // Aligned tail goes through the buffer and leaves it dirty.
    if (remaining != 0) begin
      if (buf_state == BUF_EMPTY || held_sec != sec) begin
        switch_sector(sec);
      end
      push_op(OP_COPY, sec, '0, 13'(remaining), 16'(src), '0);
      buf_state = BUF_DIRTY;
    end

    push_op(OP_DONE, '0, '0, '0, '0, len_in);
  endfunction

  // Offer one request, idling first at random, and predict it once accepted.
  task automatic send_request(input logic rtype, input logic [ADDR_BITS_DEF-1:0] addr,
                              input logic [LEN_BITS_DEF-1:0] len_in);
    while (tx_idle_on && $urandom_range(99) < 28) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid  <= 1'b1;
    req_type   <= rtype;
    start_addr <= addr;
    length     <= len_in;
    do @(posedge clk); while (req_stall);
    predict_ops(rtype, addr, len_in);
  endtask

  // Random request, biased toward a few sectors so the buffer gets reused.
  task automatic send_random_request();
    logic                     rtype;
    logic [ADDR_BITS_DEF-1:0] addr;
    logic [LEN_BITS_DEF-1:0]  len_in;
    int unsigned              pick;
    int unsigned              sec;
    int unsigned              offs;
    rtype = ($urandom_range(99) < 12) ? REQ_FLUSH : REQ_WRITE;

    pick = $urandom_range(99);
    if (pick < 5) begin
      len_in = '0;
    end else if (pick < 45) begin
      len_in = LEN_BITS_DEF'($urandom_range(1, 300));
    end else if (pick < 70) begin
      len_in = LEN_BITS_DEF'($urandom_range(1, SECTOR_BYTES_DEF));
    end else if (pick < 90) begin
      len_in = LEN_BITS_DEF'($urandom_range(SECTOR_BYTES_DEF, 20000));
    end else begin
      len_in = LEN_BITS_DEF'($urandom);
    end

    pick = $urandom_range(99);
    if (pick < 60) begin
      sec = $urandom_range(0, 7);
      sec = (sec < 4) ? sec : 508 + (sec - 4);
      pick = $urandom_range(99);
      if (pick < 30) begin
        offs = 0;
      end else if (pick < 50) begin
        offs = SECTOR_BYTES_DEF - $urandom_range(1, 64);
      end else begin
        offs = $urandom_range(0, SECTOR_BYTES_DEF - 1);
      end
      addr = ADDR_BITS_DEF'(sec * SECTOR_BYTES_DEF + offs);
    end else begin
      addr = ADDR_BITS_DEF'($urandom);
    end

    send_request(rtype, addr, len_in);
  endtask

  // Stop offering and wait until every predicted operation has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Fixed cases: empty and dirty buffer, head, whole sectors, tail, wrap.
  task automatic test_directed();
    send_request(REQ_WRITE, 21'h000000, 16'h0000);  // zero length on empty buffer
    send_request(REQ_FLUSH, 21'h1FFFFF, 16'hFFFF);  // flush while empty
    send_request(REQ_WRITE, 21'h000010, 16'd16);    // first use, short head
    send_request(REQ_WRITE, 21'h000100, 16'd32);    // same sector, still dirty
    send_request(REQ_FLUSH, 21'h000000, 16'h0000);  // flush a dirty buffer
    send_request(REQ_FLUSH, 21'h000000, 16'h0000);  // flush a clean buffer
    send_request(REQ_WRITE, 21'h001F00, 16'h0100);  // head reaches sector end
    send_request(REQ_WRITE, 21'h003010, 16'd8);     // other sector, clean buffer
    send_request(REQ_WRITE, 21'h004020, 16'd8);     // other sector, dirty buffer
    send_request(REQ_WRITE, 21'h004000, 16'h1000);  // direct write over held sector
    send_request(REQ_WRITE, 21'h005000, 16'h0010);  // tail into an empty buffer
    send_request(REQ_WRITE, 21'h007000, 16'h0020);  // tail into another sector
    send_request(REQ_WRITE, 21'h000FFF, 16'd1);     // one-byte head at sector end
    send_request(REQ_WRITE, 21'h1FFFFF, 16'hFFFF);  // longest request across the top
    send_request(REQ_WRITE, 21'h000000, 16'hFFFF);  // longest aligned request
    send_request(REQ_WRITE, 21'h1FF000, 16'h2000);  // aligned wrap to sector 0
    send_request(REQ_WRITE, 21'h000001, 16'h0FFF);  // head fills sector exactly
    send_request(REQ_WRITE, 21'h002000, 16'h1000);  // exactly one whole sector
    send_request(REQ_WRITE, 21'h002ABC, 16'h1FFF);  // head, whole sector and tail
    send_request(REQ_FLUSH, 21'h000000, 16'h0000);
    send_request(REQ_WRITE, 21'h1FFFFF, 16'h0000);  // zero length at top address
    send_request(REQ_WRITE, 21'h012345, 16'h8000);
    send_request(REQ_FLUSH, 21'h0ABCDE, 16'h1234);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_random_request();
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    @(posedge clk);
    rx_hold_left = 300;
    tx_idle_on   = 1'b0;
    repeat (30) send_random_request();
    tx_idle_on   = 1'b1;
  endtask

  // Sender pauses until the block has drained, then resumes.
  task automatic test_drain_pause();
    repeat (20) send_random_request();
    wait_for_results();
    repeat (20) send_random_request();
  endtask

  // A long stretch with neither side idling.
  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (60) send_random_request();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver stall: a counted hold-off first, else random idling.
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      res_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else if (rx_idle_on) begin
      res_stall <= ($urandom_range(99) < 28);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Compare each accepted operation with the oldest prediction.
  always @(posedge clk) begin
    fswb_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_ops.size() == 0) begin
        bad_results = bad_results + 1;
        if (bad_results <= 10) begin
          $display("unexpected operation: op %0d sector %0d", op, sector_index);
        end
      end else begin
        want = pending_ops.pop_front();
        if (op !== want.op || sector_index !== want.sector_index ||
            buffer_offset !== want.buffer_offset || byte_count !== want.byte_count ||
            source_offset !== want.source_offset || done_length !== want.done_length ||
            last !== want.last) begin
          bad_results = bad_results + 1;
          if (bad_results <= 10) begin
            $display("mismatch exp: op %0d sec %0d boff %0d cnt %0d src %0d dlen %0d last %0d",
                     want.op, want.sector_index, want.buffer_offset, want.byte_count,
                     want.source_offset, want.done_length, want.last);
            $display("         got: op %0d sec %0d boff %0d cnt %0d src %0d dlen %0d last %0d",
                     op, sector_index, buffer_offset, byte_count,
                     source_offset, done_length, last);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_type   = REQ_WRITE;
    start_addr = '0;
    length     = '0;
    held_sec   = '0;
    buf_state  = BUF_EMPTY;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(250);
    test_backpressure();
    test_drain_pause();
    test_no_idle();

    wait_for_results();
    if (bad_results == 0 && pending_ops.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/fswb_pkg.sv
rtl/core/fswb_len_unit.sv
rtl/core/flash_sector_writeback_buffer.sv
test/tb.sv
